// ===== rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg
// Shared widths, codes and types for the column raycaster and its divider.
// ----------------------------------------------------------------------------
package grc_pkg;

   // divider operand widths: |offset| << 14 over |ray|, or height << 10 over distance
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 26;

   // ray components, Q2.14 kept wide
   localparam int RAY_W   = 26;
   // camera value, Q14, signed
   localparam int CAM_W   = 23;
   // shared multiplier operands and product
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = 44;
   // side distance products along the walk
   localparam int ACC_W   = 48;
   // signed map cell index during the walk
   localparam int CELL_W  = 10;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam logic [2:0] CSR_POS_X   = 3'd0;
   localparam logic [2:0] CSR_POS_Y   = 3'd1;
   localparam logic [2:0] CSR_DIR_X   = 3'd2;
   localparam logic [2:0] CSR_DIR_Y   = 3'd3;
   localparam logic [2:0] CSR_PLANE_X = 3'd4;
   localparam logic [2:0] CSR_PLANE_Y = 3'd5;

   localparam logic [15:0] DIST_MAX = 16'hFFFF;

   typedef logic [DIV_NUM_W-1:0] div_num_type;
   typedef logic [DIV_DEN_W-1:0] div_den_type;

endpackage

// ===== rtl/grid_raycast_column.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column
// Column raycaster over a square one-bit wall map, grid walk by DDA.
// ----------------------------------------------------------------------------
// Usage: req_ words carry a command. A write command sets or clears one map
// cell as it is taken and gives no rsp_ word. A cast command traces the ray
// of one screen column from the player registers and gives one rsp_ word with
// hit side, hit cell, perpendicular distance and clamped wall span.
// csr_ writes load the player position, direction and camera plane; they are
// always taken and must only be issued while no cast is in flight.
// A cast runs the sequencer steps, two passes of the shared divider
// (distance, wall height) and a step and a map read for each visited cell.
// A zero ray on the hit axis or a zero distance skips one divider pass.
// One cast is worked at a time; req_stall stays high until its word is in
// the output register. A waiting rsp_ word does not block the next request.
// After reset the map is swept clear at one cell per cycle, all MAP_SIDE
// squared cells, with req_stall held high; csr_ writes are taken meanwhile.
// While rsp_stall is high a waiting rsp_ word holds and a finished cast waits.
// ----------------------------------------------------------------------------
module grid_raycast_column #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480,
   parameter int MAP_SIDE      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic        req_cell_wall,
   input  logic [9:0]  req_screen_column,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_out_column,
   output logic [8:0]  rsp_span_start,
   output logic [8:0]  rsp_span_end,
   output logic        rsp_hit_side,
   output logic [4:0]  rsp_hit_cell_x,
   output logic [4:0]  rsp_hit_cell_y,
   output logic [15:0] rsp_wall_distance,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import grc_pkg::*;

   localparam int DEPTH    = MAP_SIDE * MAP_SIDE;
   localparam int AW       = $clog2(DEPTH);
   localparam int MAX_WALK = 4 * (MAP_SIDE + 32) + 8;
   localparam int WALK_W   = $clog2(MAX_WALK + 1);
   localparam logic [23:0] H_HALF = 24'(SCREEN_HEIGHT / 2);
   localparam logic [23:0] H_FULL = 24'(SCREEN_HEIGHT);
   // ceil(2^37 / width): column * this >> 22 is exact for 10-bit columns
   localparam logic [33:0] CAM_RECIP =
      34'(((64'd1 << 37) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CAM   = 4'd2;
   localparam logic [3:0] ST_RAYX  = 4'd3;
   localparam logic [3:0] ST_RAYY  = 4'd4;
   localparam logic [3:0] ST_INIT  = 4'd5;
   localparam logic [3:0] ST_AX    = 4'd6;
   localparam logic [3:0] ST_AY    = 4'd7;
   localparam logic [3:0] ST_PROD  = 4'd8;
   localparam logic [3:0] ST_STEP  = 4'd9;
   localparam logic [3:0] ST_CHECK = 4'd10;
   localparam logic [3:0] ST_DIST  = 4'd11;
   localparam logic [3:0] ST_DWAIT = 4'd12;
   localparam logic [3:0] ST_LINE  = 4'd13;
   localparam logic [3:0] ST_LWAIT = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [14:0]        pos_x_ff, pos_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   // working registers
   logic [9:0]                col_ff;
   logic signed [CAM_W-1:0]   cam_ff;
   logic signed [MUL_P_W-1:0] mul_ff;
   logic signed [RAY_W-1:0]   rx_ff;
   logic [RAY_W-1:0]          arx_ff, ary_ff;
   logic                      sx_neg_ff, sy_neg_ff;
   logic [10:0]               fx_ff, fy_ff;
   logic [ACC_W-1:0]          ax_ff, ay_ff;
   logic signed [CELL_W-1:0]  mx_ff, my_ff;
   logic                      side_ff;
   logic [WALK_W-1:0]         walk_ff;
   logic                      oob_ff;
   logic                      rd_ff;
   logic [15:0]               dist_ff;
   logic [8:0]                start_ff, end_ff;
   logic [AW-1:0]             clr_ff;

   // output register
   logic        rsp_valid_ff;
   logic [9:0]  out_col_ff;
   logic [8:0]  out_start_ff, out_end_ff;
   logic        out_side_ff;
   logic [4:0]  out_cx_ff, out_cy_ff;
   logic [15:0] out_dist_ff;

   logic mem [DEPTH];

   logic req_take, out_free, out_load;

   // divider hookup
   logic        div_start, div_done;
   div_num_type div_numer, div_q;
   div_den_type div_denom;

   // multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [43:0]               cam_prod;

   logic signed [RAY_W-1:0]  ray_sum;
   logic signed [15:0]       dir_sel;
   logic [RAY_W-1:0]         ray_mag;

   logic                     take_x;
   logic signed [CELL_W-1:0] cell_step_x, cell_step_y;
   logic signed [CELL_W-1:0] mx_nx, my_nx;
   logic                     in_map;
   logic [AW-1:0]            rd_addr;

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic                     mem_wdata;

   logic signed [CELL_W-1:0] face_cell;
   logic [14:0]              face_pos;
   logic                     face_neg;
   logic signed [20:0]       face_off;
   logic [20:0]              face_mag;
   logic [RAY_W-1:0]         den_sel;
   logic [23:0]              half_line, span_lo, span_hi;

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_OUT) && out_free;

   // ---------------------------------------------------------------- datapath
   assign mul_p    = mul_a * mul_b;
   assign cam_prod = 44'(col_ff) * 44'(CAM_RECIP);

   always_comb begin
      dir_sel = (state_ff == ST_RAYY) ? dir_x_ff : dir_y_ff;
      ray_sum = RAY_W'(dir_sel) + $signed(mul_ff[RAY_W+13:14]);
      ray_mag = ray_sum[RAY_W-1] ? RAY_W'(-ray_sum) : RAY_W'(ray_sum);

      take_x      = ax_ff < ay_ff;
      cell_step_x = sx_neg_ff ? {CELL_W{1'b1}} : CELL_W'(1);
      cell_step_y = sy_neg_ff ? {CELL_W{1'b1}} : CELL_W'(1);
      mx_nx       = take_x ? mx_ff + cell_step_x : mx_ff;
      my_nx       = take_x ? my_ff : my_ff + cell_step_y;
      in_map      = !mx_nx[CELL_W-1] && (mx_nx < CELL_W'(MAP_SIDE))
                    && !my_nx[CELL_W-1] && (my_nx < CELL_W'(MAP_SIDE));
      rd_addr     = AW'(unsigned'(mx_nx)) * AW'(MAP_SIDE) + AW'(unsigned'(my_nx));

      face_cell = side_ff ? my_ff : mx_ff;
      face_pos  = side_ff ? pos_y_ff : pos_x_ff;
      face_neg  = side_ff ? sy_neg_ff : sx_neg_ff;
      face_off  = $signed({face_cell[CELL_W-1], face_cell, 10'b0})
                  - $signed({6'b0, face_pos}) + (face_neg ? 21'sd1024 : 21'sd0);
      face_mag  = face_off[20] ? 21'(-face_off) : 21'(face_off);
      den_sel   = side_ff ? ary_ff : arx_ff;

      half_line = {2'b0, div_q[22:1]};
      span_lo   = H_HALF - half_line;
      span_hi   = H_HALF + half_line;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RAYX: begin
            mul_a = MUL_A_W'(cam_ff);
            mul_b = MUL_B_W'(plane_x_ff);
         end
         ST_RAYY: begin
            mul_a = MUL_A_W'(cam_ff);
            mul_b = MUL_B_W'(plane_y_ff);
         end
         ST_AX: begin
            mul_a = $signed({1'b0, ary_ff});
            mul_b = $signed({6'b0, fx_ff});
         end
         ST_AY: begin
            mul_a = $signed({1'b0, arx_ff});
            mul_b = $signed({6'b0, fy_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      case (state_ff)
         ST_DIST: begin
            div_start = den_sel != '0;
            div_numer = DIV_NUM_W'({face_mag, 14'b0});
            div_denom = den_sel;
         end
         ST_LINE: begin
            div_start = dist_ff != '0;
            div_numer = DIV_NUM_W'(SCREEN_HEIGHT * 1024);
            div_denom = DIV_DEN_W'(dist_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_take && (req_command == CMD_CAST)) state_in = ST_CAM;
         ST_CAM:   state_in = ST_RAYX;
         ST_RAYX:  state_in = ST_RAYY;
         ST_RAYY:  state_in = ST_INIT;
         ST_INIT:  state_in = ST_AX;
         ST_AX:    state_in = ST_AY;
         ST_AY:    state_in = ST_PROD;
         ST_PROD:  state_in = ST_STEP;
         ST_STEP:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (oob_ff || rd_ff || (walk_ff == WALK_W'(MAX_WALK))) state_in = ST_DIST;
            else state_in = ST_STEP;
         end
         ST_DIST:  state_in = (den_sel == '0) ? ST_LINE : ST_DWAIT;
         ST_DWAIT: if (div_done) state_in = ST_LINE;
         ST_LINE:  state_in = (dist_ff == '0) ? ST_OUT : ST_LWAIT;
         ST_LWAIT: if (div_done) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
      end
   end

   // ---------------------------------------------------------------- map
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = 1'b0;
      end else begin
         mem_we    = req_take && (req_command == CMD_WRITE)
                     && (req_cell_x < MAP_SIDE) && (req_cell_y < MAP_SIDE);
         mem_waddr = AW'(req_cell_x) * AW'(MAP_SIDE) + AW'(req_cell_y);
         mem_wdata = req_cell_wall;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[rd_addr];
   end

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 15'd2048;
         pos_y_ff   <= 15'd2048;
         dir_x_ff   <= -16'sd16384;
         dir_y_ff   <= 16'sd0;
         plane_x_ff <= 16'sd0;
         plane_y_ff <= 16'sd10813;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POS_X:   pos_x_ff   <= csr_data[14:0];
            CSR_POS_Y:   pos_y_ff   <= csr_data[14:0];
            CSR_DIR_X:   dir_x_ff   <= $signed(csr_data);
            CSR_DIR_Y:   dir_y_ff   <= $signed(csr_data);
            CSR_PLANE_X: plane_x_ff <= $signed(csr_data);
            CSR_PLANE_Y: plane_y_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- work
   always_ff @(posedge clock) begin
      mul_ff <= mul_p;
      case (state_ff)
         ST_IDLE: col_ff <= req_screen_column;
         ST_CAM:  cam_ff <= $signed({1'b0, cam_prod[43:22]}) - CAM_W'(16384);
         ST_RAYY: begin
            rx_ff     <= ray_sum;
            arx_ff    <= ray_mag;
            sx_neg_ff <= ray_sum[RAY_W-1];
         end
         ST_INIT: begin
            ary_ff    <= ray_mag;
            sy_neg_ff <= ray_sum[RAY_W-1];
            mx_ff     <= CELL_W'({1'b0, pos_x_ff[14:10]});
            my_ff     <= CELL_W'({1'b0, pos_y_ff[14:10]});
            fx_ff     <= rx_ff[RAY_W-1] ? {1'b0, pos_x_ff[9:0]}
                                        : 11'd1024 - {1'b0, pos_x_ff[9:0]};
            fy_ff     <= ray_sum[RAY_W-1] ? {1'b0, pos_y_ff[9:0]}
                                          : 11'd1024 - {1'b0, pos_y_ff[9:0]};
            side_ff   <= 1'b1;
            walk_ff   <= '0;
         end
         ST_AY:   ax_ff <= ACC_W'(unsigned'(mul_ff));
         ST_PROD: ay_ff <= ACC_W'(unsigned'(mul_ff));
         ST_STEP: begin
            // advance one cell along the axis with the nearer grid line
            if (take_x) ax_ff <= ax_ff + (ACC_W'(ary_ff) << 10);
            else        ay_ff <= ay_ff + (ACC_W'(arx_ff) << 10);
            mx_ff   <= mx_nx;
            my_ff   <= my_nx;
            side_ff <= !take_x;
            oob_ff  <= !in_map;
            walk_ff <= walk_ff + WALK_W'(1);
         end
         ST_DIST: if (den_sel == '0) dist_ff <= DIST_MAX;
         ST_DWAIT: begin
            if (div_done)
               dist_ff <= (div_q[DIV_NUM_W-1:16] != '0) ? DIST_MAX : div_q[15:0];
         end
         ST_LINE: begin
            if (dist_ff == '0) begin
               start_ff <= '0;
               end_ff   <= 9'(SCREEN_HEIGHT - 1);
            end
         end
         ST_LWAIT: begin
            if (div_done) begin
               start_ff <= span_lo[23] ? 9'd0 : span_lo[8:0];
               end_ff   <= (span_hi >= H_FULL) ? 9'(SCREEN_HEIGHT - 1) : span_hi[8:0];
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_col_ff   <= col_ff;
         out_start_ff <= start_ff;
         out_end_ff   <= end_ff;
         out_side_ff  <= side_ff;
         out_cx_ff    <= mx_ff[4:0];
         out_cy_ff    <= my_ff[4:0];
         out_dist_ff  <= dist_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_column    = out_col_ff;
   assign rsp_span_start    = out_start_ff;
   assign rsp_span_end      = out_end_ff;
   assign rsp_hit_side      = out_side_ff;
   assign rsp_hit_cell_x    = out_cx_ff;
   assign rsp_hit_cell_y    = out_cy_ff;
   assign rsp_wall_distance = out_dist_ff;

endmodule

// ===== rtl/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  grc_pkg::div_num_type numer,
   input  grc_pkg::div_den_type denom,
   output logic                done,
   output grc_pkg::div_num_type quotient
);
   import grc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   div_num_type          quo_ff;
   div_den_type          den_ff;

   logic [DIV_DEN_W:0]   rem_sh;
   logic                 fits;
   logic [DIV_DEN_W:0]   rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= numer;
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/grc_checker.sv =====
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks for the column raycaster, bound to the top level.
// ----------------------------------------------------------------------------
module grc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [8:0]  rsp_span_start,
   input logic [8:0]  rsp_span_end,
   input logic [15:0] rsp_wall_distance
);
   import grc_pkg::*;

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_wall_distance))
      else $error("rsp distance changed under stall");

   // a cast occupies the block, so req_stall is high once it is taken
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_CAST) |=> req_stall)
      else $error("request taken straight after a cast");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_start <= rsp_span_end)
      else $error("wall span reversed");

   // the map is swept after reset
   a_clear_pass: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open right after reset");

endmodule

bind grid_raycast_column grc_checker u_grc_checker (.*);

// ===== bench/grid_raycast_column_test.sv =====
// ----------------------------------------------------------------------------
// grid_raycast_column_test
// Self-checking bench for the column raycaster: map cell writes and column
// casts under several player settings, random idling on both channels, and
// every rsp_ word compared with a predicted word.
// ----------------------------------------------------------------------------
module grid_raycast_column_test;
   import grc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = 640;
   localparam int SH = 480;
   localparam int SIDE = 32;
   localparam int WALK_LIMIT = 4 * (SIDE + 32) + 8;

   typedef struct {
      logic [9:0]  column;
      logic [8:0]  row_first;
      logic [8:0]  row_last;
      logic        side;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic [15:0] distance;
   } cast_word_type;

   class cast_scoreboard;
      bit            wall_map [SIDE*SIDE];
      longint        pos_x = 2048, pos_y = 2048;
      longint        dir_x = -16384, dir_y = 0, plane_x = 0, plane_y = 10813;
      cast_word_type pending [$];

      function longint sext16(logic [15:0] v);
         return v[15] ? longint'(v) - 65536 : longint'(v);
      endfunction

      function longint floor_q14(longint v);
         return v >= 0 ? v / 16384 : -((-v + 16383) / 16384);
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_POS_X:   pos_x = longint'(v[14:0]);
            CSR_POS_Y:   pos_y = longint'(v[14:0]);
            CSR_DIR_X:   dir_x = sext16(v);
            CSR_DIR_Y:   dir_y = sext16(v);
            CSR_PLANE_X: plane_x = sext16(v);
            CSR_PLANE_Y: plane_y = sext16(v);
            default: ;
         endcase
      endfunction

      function bit blocked(longint cx, longint cy);
         if (cx < 0 || cy < 0 || cx >= SIDE || cy >= SIDE) return 1;
         return wall_map[cx*SIDE + cy];
      endfunction

      function void note_req(logic cmd, logic [4:0] cx, logic [4:0] cy, logic wall,
                             logic [9:0] col);
         longint cam, rx, ry, arx, ary, mx, my, sx, sy, fx, fy;
         longint num, den, wall_dist, line, first, last;
         bit side;
         cast_word_type w;
         if (cmd == CMD_WRITE) begin
            wall_map[int'(cx)*SIDE + int'(cy)] = wall;
            return;
         end
         side = 1;
         cam = (longint'(col) * 32768) / SW - 16384;
         rx = dir_x + floor_q14(plane_x * cam);
         ry = dir_y + floor_q14(plane_y * cam);
         arx = rx < 0 ? -rx : rx;
         ary = ry < 0 ? -ry : ry;
         mx = pos_x / 1024;
         my = pos_y / 1024;
         if (rx < 0) begin sx = -1; fx = pos_x - mx*1024; end
         else begin sx = 1; fx = (mx+1)*1024 - pos_x; end
         if (ry < 0) begin sy = -1; fy = pos_y - my*1024; end
         else begin sy = 1; fy = (my+1)*1024 - pos_y; end
         for (int n = 0; n < WALK_LIMIT; n++) begin
            if (fx*ary < fy*arx) begin
               fx += 1024; mx += sx; side = 0;
            end else begin
               fy += 1024; my += sy; side = 1;
            end
            if (blocked(mx, my)) break;
         end
         if (side == 0) begin
            num = mx*1024 - pos_x + (sx < 0 ? 1024 : 0);
            den = arx;
         end else begin
            num = my*1024 - pos_y + (sy < 0 ? 1024 : 0);
            den = ary;
         end
         if (num < 0) num = -num;
         if (den == 0) wall_dist = 65535;
         else begin
            wall_dist = num * 16384 / den;
            if (wall_dist > 65535) wall_dist = 65535;
         end
         if (wall_dist == 0) begin
            first = 0; last = SH - 1;
         end else begin
            line = longint'(SH) * 1024 / wall_dist;
            first = SH/2 - line/2;
            last = SH/2 + line/2;
            if (first < 0) first = 0;
            if (last >= SH) last = SH - 1;
         end
         w.column = col;
         w.row_first = first[8:0];
         w.row_last = last[8:0];
         w.side = side;
         w.cell_x = mx[4:0];
         w.cell_y = my[4:0];
         w.distance = wall_dist[15:0];
         pending.push_back(w);
      endfunction

      // empty string when the word matches
      function string check_rsp(cast_word_type got);
         cast_word_type e;
         string s;
         if (pending.size() == 0) return "rsp word with nothing expected";
         e = pending.pop_front();
         s = "";
         if (got.column !== e.column) s = {s, $sformatf(" column %0d/%0d", got.column, e.column)};
         if (got.row_first !== e.row_first)
            s = {s, $sformatf(" start %0d/%0d", got.row_first, e.row_first)};
         if (got.row_last !== e.row_last)
            s = {s, $sformatf(" end %0d/%0d", got.row_last, e.row_last)};
         if (got.side !== e.side) s = {s, $sformatf(" side %0d/%0d", got.side, e.side)};
         if (got.cell_x !== e.cell_x) s = {s, $sformatf(" cx %0d/%0d", got.cell_x, e.cell_x)};
         if (got.cell_y !== e.cell_y) s = {s, $sformatf(" cy %0d/%0d", got.cell_y, e.cell_y)};
         if (got.distance !== e.distance)
            s = {s, $sformatf(" dist %0d/%0d", got.distance, e.distance)};
         if (s != "") s = {$sformatf("column %0d:", e.column), s};
         return s;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_command = 0, req_cell_wall = 0;
   logic [4:0]  req_cell_x = 0, req_cell_y = 0;
   logic [9:0]  req_screen_column = 0;
   logic        req_stall, rsp_valid, rsp_hit_side, csr_ready;
   logic        rsp_stall = 0;
   logic [9:0]  rsp_out_column;
   logic [8:0]  rsp_span_start, rsp_span_end;
   logic [4:0]  rsp_hit_cell_x, rsp_hit_cell_y;
   logic [15:0] rsp_wall_distance;
   logic        csr_valid = 0;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   cast_scoreboard sb = new();
   int  mismatches = 0;
   int  send_pct = 0, recv_pct = 0;
   bit  idle_on = 0;

   grid_raycast_column DUT (.*);

   always #2 clock = ~clock;

   task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   always @(negedge clock)
      rsp_stall = idle_on && ($urandom_range(99) < recv_pct);

   always @(posedge clock) begin
      cast_word_type got;
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.column = rsp_out_column;
         got.row_first = rsp_span_start;
         got.row_last = rsp_span_end;
         got.side = rsp_hit_side;
         got.cell_x = rsp_hit_cell_x;
         got.cell_y = rsp_hit_cell_y;
         got.distance = rsp_wall_distance;
         msg = sb.check_rsp(got);
         if (msg != "") report(msg);
      end
   end

   task send_word(logic cmd, logic [4:0] cx, logic [4:0] cy, logic wall, logic [9:0] col);
      while (idle_on && $urandom_range(99) < send_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_command = cmd;
      req_cell_x = cx;
      req_cell_y = cy;
      req_cell_wall = wall;
      req_screen_column = col;
      req_valid = 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_req(cmd, cx, cy, wall, col);
      @(negedge clock);
   endtask

   task write_csr(logic [2:0] idx, logic [15:0] v);
      csr_index = idx;
      csr_data = v;
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // hold until every cast is back, then let any cell write settle
   task drain;
      req_valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task load_setting(int k);
      logic [15:0] v [6];
      for (int i = 0; i < 6; i++) v[i] = 16'($urandom());
      case (k)
         0: begin v[0] = 0; v[1] = 0; v[2] = 16'h8000; v[3] = 16'h7FFF; end
         1: begin v[0] = 16'h7FFF; v[1] = 16'h7FFF; v[2] = 16'h7FFF; v[3] = 16'h8000; end
         2: begin v[2] = 0; v[3] = 0; v[4] = 0; v[5] = 0; end
         3: begin v[3] = 0; v[5] = 0; end
         4: begin v[2] = 0; v[4] = 0; v[4] = 16'h8000; v[5] = 16'h7FFF; end
         default: ;
      endcase
      // keep most positions inside the map body
      if (k >= 5) begin
         v[0] = 16'($urandom_range(31*1024 + 1023, 1024));
         v[1] = 16'($urandom_range(31*1024 + 1023, 1024));
      end
      write_csr(CSR_POS_X, v[0]);
      write_csr(CSR_POS_Y, v[1]);
      write_csr(CSR_DIR_X, v[2]);
      write_csr(CSR_DIR_Y, v[3]);
      write_csr(CSR_PLANE_X, v[4]);
      write_csr(CSR_PLANE_Y, v[5]);
   endtask

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: defaults first, then map corners and column extremes
      send_word(CMD_CAST, 0, 0, 0, 10'd0);
      send_word(CMD_CAST, 0, 0, 0, 10'd639);
      send_word(CMD_CAST, 0, 0, 0, 10'd320);
      send_word(CMD_CAST, 0, 0, 0, 10'd1023);
      send_word(CMD_WRITE, 5'd0, 5'd0, 1, 0);
      send_word(CMD_WRITE, 5'd31, 5'd31, 1, 0);
      send_word(CMD_WRITE, 5'd1, 5'd2, 1, 0);
      send_word(CMD_WRITE, 5'd0, 5'd2, 1, 0);
      send_word(CMD_CAST, 0, 0, 0, 10'd100);
      send_word(CMD_CAST, 0, 0, 0, 10'd500);
      send_word(CMD_WRITE, 5'd1, 5'd2, 0, 0);
      send_word(CMD_CAST, 0, 0, 0, 10'd320);
      for (int k = 0; k < 5; k++) begin
         drain();
         load_setting(k);
         send_word(CMD_CAST, 0, 0, 0, 10'd0);
         send_word(CMD_CAST, 0, 0, 0, 10'd1023);
      end
      drain();
      send_word(CMD_WRITE, 5'd0, 5'd0, 0, 0);
      send_word(CMD_WRITE, 5'd31, 5'd31, 0, 0);
      // random phases with three idling regimes
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         load_setting(ph < 2 ? ph : ph + 3);
         if (ph < 3) begin send_pct = 7; recv_pct = 87; end
         else if (ph < 6) begin send_pct = 87; recv_pct = 7; end
         else begin send_pct = 0; recv_pct = 0; end
         for (int i = 0; i < 228; i++) begin
            idle_on = ((i / 40) % 3) != 2;
            if ($urandom_range(1))
               send_word(CMD_WRITE, 5'($urandom()), 5'($urandom()),
                         $urandom_range(99) < 30, 0);
            else if ($urandom_range(9) == 0)
               send_word(CMD_CAST, 0, 0, 0, 10'($urandom_range(1023, 640)));
            else
               send_word(CMD_CAST, 5'($urandom()), 5'($urandom()), 1'($urandom()),
                         10'($urandom_range(639)));
         end
      end
      idle_on = 0;
      drain();
      repeat (800) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
